### rtl/asp_pkg.sv
package asp_pkg;

  localparam int COLOUR_ENTRIES = 16;
  localparam int PARAM_W = 10;
  localparam logic [PARAM_W-1:0] PARAM_MAX = 10'd1023;
  localparam logic [4:0] DEF_IDX = 5'd16;

  // register indexes on the config port
  localparam logic REG_DEFAULT_FG = 1'b0;
  localparam logic REG_DEFAULT_BG = 1'b1;

  localparam logic [7:0] CH_BEL  = 8'h07;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;  // '['
  localparam logic [7:0] CH_RBR  = 8'h5D;  // ']'
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CH_M    = 8'h6D;  // 'm'
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7E;

  // SGR parameter codes
  localparam logic [PARAM_W-1:0] SGR_RESET        = 10'd0;
  localparam logic [PARAM_W-1:0] SGR_BOLD         = 10'd1;
  localparam logic [PARAM_W-1:0] SGR_LIGHT        = 10'd2;
  localparam logic [PARAM_W-1:0] SGR_ITALIC       = 10'd3;
  localparam logic [PARAM_W-1:0] SGR_UNDERLINE    = 10'd4;
  localparam logic [PARAM_W-1:0] SGR_FG_LO        = 10'd30;
  localparam logic [PARAM_W-1:0] SGR_FG_HI        = 10'd37;
  localparam logic [PARAM_W-1:0] SGR_BG_LO        = 10'd40;
  localparam logic [PARAM_W-1:0] SGR_BG_HI        = 10'd47;
  localparam logic [PARAM_W-1:0] SGR_FG_BRIGHT_LO = 10'd90;
  localparam logic [PARAM_W-1:0] SGR_FG_BRIGHT_HI = 10'd97;
  localparam logic [PARAM_W-1:0] SGR_BG_BRIGHT_LO = 10'd100;
  localparam logic [PARAM_W-1:0] SGR_BG_BRIGHT_HI = 10'd107;

  localparam logic [1:0] KIND_CHAR       = 2'd0;
  localparam logic [1:0] KIND_NEWLINE    = 2'd1;
  localparam logic [1:0] KIND_ERASE_CHAR = 2'd2;
  localparam logic [1:0] KIND_ERASE      = 2'd3;

  localparam logic [1:0] WEIGHT_NORMAL = 2'd0;
  localparam logic [1:0] WEIGHT_BOLD   = 2'd1;
  localparam logic [1:0] WEIGHT_LIGHT  = 2'd2;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_CR     = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_OSC    = 3'd3,
    MODE_CSI    = 3'd4
  } mode_t;

  typedef struct packed {
    logic       underline;
    logic       italic;
    logic [1:0] weight;
    logic [4:0] bg;
    logic [4:0] fg;
  } attr_t;

  localparam attr_t DEF_ATTRS = '{underline: 1'b0, italic: 1'b0, weight: WEIGHT_NORMAL,
                                  bg: DEF_IDX, fg: DEF_IDX};

  typedef struct packed {
    logic [PARAM_W-1:0] value;
    logic               has_digit;
    logic               invalid;
  } param_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:  rgb = 24'h010101;
      4'd1:  rgb = 24'hDE382B;
      4'd2:  rgb = 24'h39B54A;
      4'd3:  rgb = 24'hFFC706;
      4'd4:  rgb = 24'h006FB8;
      4'd5:  rgb = 24'h762671;
      4'd6:  rgb = 24'h2CB5E9;
      4'd7:  rgb = 24'hCCCCCC;
      4'd8:  rgb = 24'h808080;
      4'd9:  rgb = 24'hFF0000;
      4'd10: rgb = 24'h00FF00;
      4'd11: rgb = 24'hFFFF00;
      4'd12: rgb = 24'h0000FF;
      4'd13: rgb = 24'hFF00FF;
      4'd14: rgb = 24'h00FFFF;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

### rtl/asp_sgr_apply.sv
// Applies one finished SGR parameter to the pending attribute set.
module asp_sgr_apply (
  input  asp_pkg::param_t prm,
  input  asp_pkg::attr_t  pending,
  output asp_pkg::attr_t  updated
);
  import asp_pkg::*;

  logic [PARAM_W-1:0] n;
  logic [PARAM_W-1:0] d30, d90, d40, d100;

  assign n    = prm.value;
  assign d30  = n - SGR_FG_LO;
  assign d90  = n - SGR_FG_BRIGHT_LO;
  assign d40  = n - SGR_BG_LO;
  assign d100 = n - SGR_BG_BRIGHT_LO;

  always_comb begin
    updated = pending;
    if (prm.has_digit && !prm.invalid) begin
      priority if (n == SGR_RESET) begin
        updated = DEF_ATTRS;
      end else if (n == SGR_BOLD) begin
        updated.weight = WEIGHT_BOLD;
      end else if (n == SGR_LIGHT) begin
        updated.weight = WEIGHT_LIGHT;
      end else if (n == SGR_ITALIC) begin
        updated.italic = 1'b1;
      end else if (n == SGR_UNDERLINE) begin
        updated.underline = 1'b1;
      end else if (n >= SGR_FG_LO && n <= SGR_FG_HI) begin
        updated.fg = {2'b00, d30[2:0]};
      end else if (n >= SGR_FG_BRIGHT_LO && n <= SGR_FG_BRIGHT_HI) begin
        updated.fg = {2'b01, d90[2:0]};
      end else if (n >= SGR_BG_LO && n <= SGR_BG_HI) begin
        updated.bg = {2'b00, d40[2:0]};
      end else if (n >= SGR_BG_BRIGHT_LO && n <= SGR_BG_BRIGHT_HI) begin
        updated.bg = {2'b01, d100[2:0]};
      end else begin
        // unknown code, saturated values included
        updated = pending;
      end
    end
  end

endmodule

### rtl/ansi_sgr_escape_parser.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------------------
// input    | in_valid / in_ready    | char_code
// result   | out_valid / out_ready  | kind, out_char, fg_rgb, bg_rgb, weight,
//          |                        | italic, underline
// config   | cfg_we (no wait)       | cfg_index, cfg_data
//
// One byte per cycle sustained unless a stalled result holds it back. A byte is held
// in the input register, where the mode FSM, the parameter accumulator and SGR update
// resolve it in a single pass; a byte that emits then loads the output register.
// rst (synchronous) restores the default colors, normal mode and default attributes.
// A stalled result only holds back a byte that itself emits; the input register
// keeps taking beats while it is empty or moving.
module ansi_sgr_escape_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_char,
  output logic [23:0] fg_rgb,
  output logic [23:0] bg_rgb,
  output logic [1:0]  weight,
  output logic        italic,
  output logic        underline
);
  import asp_pkg::*;

  logic [23:0] default_fg, default_bg;
  mode_t       mode, mode_next;
  param_t      prm, prm_next;
  attr_t       pending, pending_next, current, current_next, sgr_out;

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_go;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [7:0]  emit_char;

  logic        is_digit, is_final;
  logic [13:0] acc;

  assign is_digit = (s1_char >= CH_ZERO) && (s1_char <= CH_NINE);
  assign is_final = (s1_char >= FINAL_LO) && (s1_char <= FINAL_HI);
  assign acc = ({4'b0, prm.value} * 14'd10) + {6'b0, s1_char - CH_ZERO};

  asp_sgr_apply u_sgr (
    .prm     (prm),
    .pending (pending),
    .updated (sgr_out)
  );

  assign s1_go    = s1_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  // next mode
  always_comb begin
    mode_next = MODE_NORMAL;
    unique case (mode)
      MODE_CR: begin
        priority if (s1_char == CH_CR) mode_next = MODE_CR;
        else if (s1_char == CH_ESC) mode_next = MODE_ESC;
        else mode_next = MODE_NORMAL;
      end
      MODE_ESC: begin
        priority if (s1_char == CH_LBR) mode_next = MODE_CSI;
        else if (s1_char == CH_RBR) mode_next = MODE_OSC;
        else mode_next = MODE_NORMAL;
      end
      MODE_OSC: begin
        mode_next = (s1_char == CH_BEL) ? MODE_NORMAL : MODE_OSC;
      end
      MODE_CSI: begin
        priority if (is_digit || s1_char == CH_SEMI) mode_next = MODE_CSI;
        else if (is_final) mode_next = MODE_NORMAL;
        else mode_next = MODE_CSI;
      end
      default: begin
        priority if (s1_char == CH_ESC) mode_next = MODE_ESC;
        else if (s1_char == CH_CR) mode_next = MODE_CR;
        else mode_next = MODE_NORMAL;
      end
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    emit         = 1'b0;
    emit_kind    = KIND_CHAR;
    emit_char    = 8'd0;
    prm_next     = prm;
    pending_next = pending;
    current_next = current;
    unique case (mode)
      MODE_CR: begin
        emit = 1'b1;
        priority if (s1_char == CH_CR || s1_char == CH_ESC) begin
          emit_kind = KIND_ERASE;
        end else if (s1_char == CH_LF) begin
          emit_kind = KIND_NEWLINE;
        end else begin
          emit_kind = KIND_ERASE_CHAR;
          emit_char = s1_char;
        end
      end
      MODE_ESC: begin
        if (s1_char == CH_LBR) begin
          prm_next     = '0;
          pending_next = DEF_ATTRS;
        end
      end
      MODE_OSC: begin
      end
      MODE_CSI: begin
        priority if (is_digit) begin
          prm_next.value     = (acc > {4'b0, PARAM_MAX}) ? PARAM_MAX : acc[PARAM_W-1:0];
          prm_next.has_digit = 1'b1;
        end else if (s1_char == CH_SEMI) begin
          prm_next     = '0;
          pending_next = sgr_out;
        end else if (s1_char == CH_M) begin
          prm_next     = '0;
          pending_next = sgr_out;
          current_next = sgr_out;
        end else if (is_final) begin
          prm_next = '0;
        end else begin
          prm_next.invalid = 1'b1;
        end
      end
      default: begin
        if (s1_char != CH_ESC && s1_char != CH_CR) begin
          emit = 1'b1;
          if (s1_char == CH_LF) begin
            emit_kind = KIND_NEWLINE;
          end else begin
            emit_kind = KIND_CHAR;
            emit_char = s1_char;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_fg <= 24'hCCCCCC;
      default_bg <= 24'h000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_FG: default_fg <= cfg_data;
        REG_DEFAULT_BG: default_bg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) s1_char <= char_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      prm     <= '0;
      pending <= DEF_ATTRS;
      current <= DEF_ATTRS;
    end else if (s1_go) begin
      mode    <= mode_next;
      prm     <= prm_next;
      pending <= pending_next;
      current <= current_next;
    end
  end

  // result register: loads a beat from the parse stage, drops it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && emit) begin
      kind      <= emit_kind;
      out_char  <= emit_char;
      fg_rgb    <= current.fg[4] ? default_fg : palette(current.fg[3:0]);
      bg_rgb    <= current.bg[4] ? default_bg : palette(current.bg[3:0]);
      weight    <= current.weight;
      italic    <= current.italic;
      underline <= current.underline;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_char))
    else $error("parse stage lost a stalled byte");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_char))
    else $error("result overwritten while stalled");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NEWLINE || kind == KIND_ERASE) |-> out_char == 8'd0)
    else $error("non-char result carries a character");

  a_weight_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weight != 2'd3)
    else $error("bad weight code");

  a_esc_enters_csi: assert property (@(posedge clk) disable iff (rst)
    s1_go && mode == MODE_ESC && s1_char == CH_LBR |=> mode == MODE_CSI && prm == '0)
    else $error("CSI entry did not clear the parameter");
`endif

endmodule

### test/asp_tb_pkg.sv
package asp_tb_pkg;

  // bright codes land in the upper half of the color table
  localparam int BRIGHT_OFFSET = 8;

endpackage

### test/ansi_sgr_escape_parser_checker.sv
module ansi_sgr_escape_parser_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  out_char,
  input  logic [23:0] fg_rgb,
  input  logic [23:0] bg_rgb,
  input  logic [1:0]  weight,
  input  logic        italic,
  input  logic        underline,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import asp_pkg::*;
  import asp_tb_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [23:0] fg;
    logic [23:0] bg;
    logic [1:0]  weight;
    logic        italic;
    logic        underline;
  } glyph_t;

  logic [23:0] colour_table [16] = '{
    24'h010101, 24'hDE382B, 24'h39B54A, 24'hFFC706,
    24'h006FB8, 24'h762671, 24'h2CB5E9, 24'hCCCCCC,
    24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  mode_t        mode;
  logic [9:0]   acc;
  logic         acc_digit;
  logic         acc_bad;
  attr_t        pend;
  attr_t        cur;
  logic [23:0]  dflt_fg;
  logic [23:0]  dflt_bg;
  glyph_t       expected_glyphs [$];

  function automatic logic [23:0] rgb_of(input logic [4:0] idx, input logic [23:0] dflt);
    if (idx < 5'(COLOUR_ENTRIES)) return colour_table[idx[3:0]];
    return dflt;
  endfunction

  function void push_glyph(input logic [1:0] k, input logic [7:0] ch);
    glyph_t g;
    g.kind      = k;
    g.ch        = ch;
    g.fg        = rgb_of(cur.fg, dflt_fg);
    g.bg        = rgb_of(cur.bg, dflt_bg);
    g.weight    = cur.weight;
    g.italic    = cur.italic;
    g.underline = cur.underline;
    expected_glyphs.push_back(g);
  endfunction

  function void clear_param();
    acc = '0;
    acc_digit = 1'b0;
    acc_bad = 1'b0;
  endfunction

  // apply one finished SGR parameter to the pending attributes
  function void close_param();
    int n;
    n = int'(acc);
    if (acc_digit && !acc_bad) begin
      if (n == SGR_RESET) pend = DEF_ATTRS;
      else if (n == SGR_BOLD) pend.weight = WEIGHT_BOLD;
      else if (n == SGR_LIGHT) pend.weight = WEIGHT_LIGHT;
      else if (n == SGR_ITALIC) pend.italic = 1'b1;
      else if (n == SGR_UNDERLINE) pend.underline = 1'b1;
      else if (n >= SGR_FG_LO && n <= SGR_FG_HI) pend.fg = 5'(n - SGR_FG_LO);
      else if (n >= SGR_FG_BRIGHT_LO && n <= SGR_FG_BRIGHT_HI)
        pend.fg = 5'(n - SGR_FG_BRIGHT_LO + BRIGHT_OFFSET);
      else if (n >= SGR_BG_LO && n <= SGR_BG_HI) pend.bg = 5'(n - SGR_BG_LO);
      else if (n >= SGR_BG_BRIGHT_LO && n <= SGR_BG_BRIGHT_HI)
        pend.bg = 5'(n - SGR_BG_BRIGHT_LO + BRIGHT_OFFSET);
    end
    clear_param();
  endfunction

  function void advance_parser(input logic [7:0] c);
    int v;
    case (mode)
      MODE_CR: begin
        if (c == CH_CR) begin
          push_glyph(KIND_ERASE, 8'h00);
        end else if (c == CH_LF) begin
          mode = MODE_NORMAL;
          push_glyph(KIND_NEWLINE, 8'h00);
        end else if (c == CH_ESC) begin
          mode = MODE_ESC;
          push_glyph(KIND_ERASE, 8'h00);
        end else begin
          mode = MODE_NORMAL;
          push_glyph(KIND_ERASE_CHAR, c);
        end
      end
      MODE_ESC: begin
        if (c == CH_LBR) begin
          mode = MODE_CSI;
          clear_param();
          pend = DEF_ATTRS;
        end else if (c == CH_RBR) begin
          mode = MODE_OSC;
        end else begin
          mode = MODE_NORMAL;
        end
      end
      MODE_OSC: begin
        if (c == CH_BEL) mode = MODE_NORMAL;
      end
      MODE_CSI: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          v = int'(acc) * 10 + int'(c - CH_ZERO);
          acc = (v > int'(PARAM_MAX)) ? PARAM_MAX : 10'(v);
          acc_digit = 1'b1;
        end else if (c == CH_SEMI) begin
          close_param();
        end else if (c == CH_M) begin
          close_param();
          cur = pend;
          mode = MODE_NORMAL;
        end else if (c >= FINAL_LO && c <= FINAL_HI) begin
          clear_param();
          mode = MODE_NORMAL;
        end else begin
          acc_bad = 1'b1;
        end
      end
      default: begin
        mode = MODE_NORMAL;
        if (c == CH_ESC) mode = MODE_ESC;
        else if (c == CH_CR) mode = MODE_CR;
        else if (c == CH_LF) push_glyph(KIND_NEWLINE, 8'h00);
        else push_glyph(KIND_CHAR, c);
      end
    endcase
  endfunction

  function void check_glyph();
    glyph_t got;
    glyph_t want;
    got.kind      = kind;
    got.ch        = out_char;
    got.fg        = fg_rgb;
    got.bg        = bg_rgb;
    got.weight    = weight;
    got.italic    = italic;
    got.underline = underline;
    if (expected_glyphs.size() == 0) begin
      if (fail_count < REPORT_LIMIT)
        $display("%0t: unexpected beat kind=%0d char=%h fg=%h bg=%h w=%0d i=%0b u=%0b",
                 $time, got.kind, got.ch, got.fg, got.bg, got.weight, got.italic,
                 got.underline);
      fail_count++;
    end else begin
      want = expected_glyphs.pop_front();
      if (got.kind !== want.kind || got.ch !== want.ch || got.fg !== want.fg ||
          got.bg !== want.bg || got.weight !== want.weight ||
          got.italic !== want.italic || got.underline !== want.underline) begin
        if (fail_count < REPORT_LIMIT) begin
          $display("%0t: exp kind=%0d char=%h fg=%h bg=%h w=%0d i=%0b u=%0b", $time,
                   want.kind, want.ch, want.fg, want.bg, want.weight, want.italic,
                   want.underline);
          $display("%0t: got kind=%0d char=%h fg=%h bg=%h w=%0d i=%0b u=%0b", $time,
                   got.kind, got.ch, got.fg, got.bg, got.weight, got.italic,
                   got.underline);
        end
        fail_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_NORMAL;
      clear_param();
      pend = DEF_ATTRS;
      cur = DEF_ATTRS;
      dflt_fg = 24'hCCCCCC;
      dflt_bg = 24'h000000;
      expected_glyphs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DEFAULT_FG) dflt_fg = cfg_data;
        else dflt_bg = cfg_data;
      end
      // a result leaving now always belongs to an earlier byte
      if (out_valid && out_ready) check_glyph();
      if (in_valid && in_ready) advance_parser(char_code);
    end
    pending_count = expected_glyphs.size();
  end

endmodule

### test/ansi_sgr_escape_parser_tb.sv
module ansi_sgr_escape_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asp_pkg::*;
  import asp_tb_pkg::*;

  localparam int ITEM_TARGET   = 1750;
  localparam int PHASES        = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  out_char;
  logic [23:0] fg_rgb;
  logic [23:0] bg_rgb;
  logic [1:0]  weight;
  logic        italic;
  logic        underline;

  int fail_count;
  int pending_count;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_request = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  logic [7:0] burst [$];

  always #6 clk = ~clk;

  ansi_sgr_escape_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .char_code(char_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_char(out_char), .fg_rgb(fg_rgb), .bg_rgb(bg_rgb),
    .weight(weight), .italic(italic), .underline(underline)
  );

  ansi_sgr_escape_parser_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .char_code(char_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_char(out_char), .fg_rgb(fg_rgb), .bg_rgb(bg_rgb),
    .weight(weight), .italic(italic), .underline(underline),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic flush_burst();
    while (burst.size() != 0) send_byte(burst.pop_front());
  endtask

  // stop sending and let every expected beat come out, plus pipeline settle
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_defaults(input logic [23:0] fg, input logic [23:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEFAULT_FG;
    cfg_data  <= fg;
    @(negedge clk);
    cfg_index <= REG_DEFAULT_BG;
    cfg_data  <= bg;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function void add_number(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endfunction

  function int pick_sgr_code();
    case ($urandom_range(0, 8))
      0: return SGR_RESET;
      1: return int'($urandom_range(SGR_BOLD, SGR_UNDERLINE));
      2, 3: return int'($urandom_range(SGR_FG_LO, SGR_FG_HI));
      4: return int'($urandom_range(SGR_FG_BRIGHT_LO, SGR_FG_BRIGHT_HI));
      5, 6: return int'($urandom_range(SGR_BG_LO, SGR_BG_HI));
      7: return int'($urandom_range(SGR_BG_BRIGHT_LO, SGR_BG_BRIGHT_HI));
      default: return int'($urandom_range(0, 200));
    endcase
  endfunction

  // a byte that is neither a digit, ';' nor a CSI final
  function logic [7:0] pick_stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI ||
           (b >= FINAL_LO && b <= FINAL_HI));
    return b;
  endfunction

  function void add_param();
    case ($urandom_range(0, 9))
      6: ;  // empty parameter
      7: add_number(int'($urandom_range(1024, 999999)));  // saturates
      8: begin
        if ($urandom_range(0, 1)) begin
          burst.push_back(pick_stray_byte());
          add_number(pick_sgr_code());
        end else begin
          add_number(pick_sgr_code());
          burst.push_back(pick_stray_byte());
        end
      end
      9: begin
        repeat ($urandom_range(1, 4)) burst.push_back(CH_ZERO);
        add_number(pick_sgr_code());
      end
      default: add_number(pick_sgr_code());
    endcase
  endfunction

  function void add_sgr_sequence();
    int nparams;
    logic [7:0] fin;
    burst.push_back(CH_ESC);
    burst.push_back(CH_LBR);
    nparams = int'($urandom_range(0, 4));
    for (int i = 0; i < nparams; i++) begin
      if (i > 0) burst.push_back(CH_SEMI);
      add_param();
    end
    if ($urandom_range(0, 9) == 0) begin
      fin = 8'($urandom_range(FINAL_LO, FINAL_HI));
      if (fin == CH_M) fin = FINAL_HI;
      burst.push_back(fin);
    end else begin
      burst.push_back(CH_M);
    end
  endfunction

  function void add_text(input int len);
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) burst.push_back(8'($urandom_range(0, 255)));
      else burst.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
  endfunction

  function void add_random_chunk();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: add_sgr_sequence();
      5: begin
        burst.push_back(CH_ESC);
        burst.push_back(CH_RBR);
        repeat ($urandom_range(0, 6)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_BEL);
          burst.push_back(b);
        end
        burst.push_back(CH_BEL);
      end
      6: begin
        burst.push_back(CH_ESC);
        do b = 8'($urandom_range(0, 255)); while (b == CH_LBR || b == CH_RBR);
        burst.push_back(b);
      end
      7: burst.push_back(CH_LF);
      8: begin
        burst.push_back(CH_CR);
        case ($urandom_range(0, 3))
          0: burst.push_back(CH_CR);
          1: burst.push_back(CH_LF);
          2: add_sgr_sequence();
          default: burst.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      9: burst.push_back(CH_CR);
      default: add_text(int'($urandom_range(1, 8)));
    endcase
    add_text(int'($urandom_range(0, 4)));
  endfunction

  initial begin
    int phase_start;
    int per_phase;
    rst       = 1'b1;
    in_valid  = 1'b0;
    char_code = 8'h00;
    cfg_we    = 1'b0;
    cfg_index = REG_DEFAULT_FG;
    cfg_data  = 24'h000000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, every CR follow-up, CSI with bright codes,
    // empty CSI, OSC string
    burst.push_back("A");
    burst.push_back(8'h00);
    burst.push_back(8'hFF);
    burst.push_back(CH_LF);
    burst.push_back(CH_CR);
    burst.push_back(CH_CR);
    burst.push_back("b");
    burst.push_back(CH_CR);
    burst.push_back(CH_LF);
    burst.push_back(CH_CR);
    burst.push_back(CH_ESC);
    burst.push_back(CH_LBR);
    add_number(SGR_BG_BRIGHT_HI);
    burst.push_back(CH_SEMI);
    add_number(SGR_FG_BRIGHT_HI);
    burst.push_back(CH_M);
    burst.push_back("Z");
    burst.push_back(CH_ESC);
    burst.push_back(CH_LBR);
    burst.push_back(CH_M);
    burst.push_back(CH_ESC);
    burst.push_back(CH_RBR);
    burst.push_back("x");
    burst.push_back(CH_BEL);
    burst.push_back("Z");
    flush_burst();

    per_phase = ITEM_TARGET / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      case (p)
        0: write_defaults(24'h000000, 24'hFFFFFF);
        1: write_defaults(24'hFFFFFF, 24'h000000);
        2: write_defaults(24'hCCCCCC, 24'h000000);
        default: write_defaults(24'($urandom), 24'($urandom));
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      phase_start = bytes_sent;
      if (p == 4) begin
        // long output stall while text keeps coming, so the input backs up
        hold_request = HOLD_CYCLES;
        add_text(40);
        flush_burst();
      end
      while (bytes_sent - phase_start < per_phase) begin
        add_random_chunk();
        flush_burst();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
